### design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, ck, rs, pre, post) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

### design/cu2d_pkg.sv
// shared types, constants and helpers for the compact integer to decimal block
// no dependencies
package cu2d_pkg;

  // prefix byte classes and length field
  localparam logic [7:0] PFX_TWO  = 8'h40;
  localparam logic [7:0] PFX_FOUR = 8'h80;
  localparam logic [7:0] PFX_LONG = 8'hC0;
  localparam logic [5:0] LOW_MASK = 6'h3F;
  localparam int LEN_BIAS = 4;
  localparam int MAX_VALUE_BYTES = 32;
  localparam int DEC_DIGITS_DEF = 80;

  // result field widths
  localparam int GROUP_W = 16;
  localparam int NDIG_W  = 3;
  localparam int LEN_W   = 6;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT,
    ST_ERR
  } state_t;

  // operations of the shared digit unit
  typedef enum logic [1:0] {
    BCD_HOLD,
    BCD_CLEAR,
    BCD_DOUBLE,
    BCD_GROUP
  } bcd_op_t;

  typedef struct packed {
    bcd_op_t op;
    logic    bit_in;
  } bcd_ctrl_t;

  typedef struct packed {
    logic [GROUP_W-1:0] digit_group;
    logic [NDIG_W-1:0]  digits_in_group;
    logic               last_group;
    logic               status;
    logic [LEN_W-1:0]   encoded_length;
  } result_t;

  // number of significant digits in the leading group, at least one
  function automatic logic [NDIG_W-1:0] lead_digits(input logic [GROUP_W-1:0] grp);
    logic [NDIG_W-1:0] n;
    if (grp[15:12] != 4'd0) begin
      n = 3'd4;
    end else if (grp[11:8] != 4'd0) begin
      n = 3'd3;
    end else if (grp[7:4] != 4'd0) begin
      n = 3'd2;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

endpackage

### design/compact_u256_to_decimal.sv
// Compact unsigned integer stream decoder with decimal digit output.
// Input channel s_*: one encoded byte per transfer, prefix byte first.
// Output channel m_*: decimal digit groups of up to four BCD nibbles,
// most significant group first; m_tlast marks the final group of a value.
// An over-long prefix gives one error transfer (m_tuser high) from the error state.
// Each accepted transfer starts the shared digit unit, which runs one
// doubling step per value bit: the eight bits of a payload byte, the six
// low bits of a prefix carrying value bits, none for a long-form prefix.
// s_tready is low while the unit works, so the next byte waits for it.
// After the last byte, of its (DEC_DIGITS+3)/4 groups the sequencer skips
// leading zero ones at one per cycle, then emits one group per cycle while out_free is high.
// The output register frees the input side: the next byte is taken while
// a result waits. If m_tready stays low the sequencer holds the next group.
// Reset (rst, synchronous) empties the output register and returns to
// awaiting a prefix byte.
// depends on cu2d_pkg, cu2d_bcd_unit, cu2d_ctrl
module compact_u256_to_decimal import cu2d_pkg::*; #(
  parameter int DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [15:0] digit_group, [18:16] digits_in_group,
                                 // [24:19] encoded_length, [31:25] zero
  output logic        m_tlast,   // last_group
  output logic        m_tuser    // [0] status
);

  bcd_ctrl_t          bcd;
  logic [GROUP_W-1:0] top_group;
  logic               top_zero;
  logic               load;
  logic               out_free;
  result_t            res;
  result_t            out_res;

  cu2d_bcd_unit #(.DEC_DIGITS(DEC_DIGITS)) u_bcd (
    .clk       (clk),
    .ctrl      (bcd),
    .top_group (top_group),
    .top_zero  (top_zero)
  );

  cu2d_ctrl #(.DEC_DIGITS(DEC_DIGITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .out_free  (out_free),
    .load      (load),
    .res       (res),
    .bcd       (bcd),
    .top_group (top_group),
    .top_zero  (top_zero)
  );

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {7'd0, out_res.encoded_length, out_res.digits_in_group,
                    out_res.digit_group};
  assign m_tlast = out_res.last_group;
  assign m_tuser = out_res.status;

endmodule

### design/cu2d_bcd_unit.sv
// decimal digit register with its shared double-and-add / group-shift unit
// depends on cu2d_pkg
module cu2d_bcd_unit import cu2d_pkg::*; #(
  parameter int DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic               clk,
  input  bcd_ctrl_t          ctrl,
  output logic [GROUP_W-1:0] top_group,
  output logic               top_zero
);

  localparam int NGRP = (DEC_DIGITS + 3) / 4;
  localparam int NDIG = NGRP * 4;

  logic [3:0] dig      [NDIG];
  logic [3:0] dig_next [NDIG];
  logic [3:0] adj      [NDIG];

  // add three to digits of five and up before the doubling shift
  for (genvar i = 0; i < NDIG; i++) begin : g_adj
    assign adj[i] = (dig[i] >= 4'd5) ? dig[i] + 4'd3 : dig[i];
  end

  // next value of each digit cell
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    logic [3:0] dbl;
    logic [3:0] grp_in;
    if (i >= DEC_DIGITS) begin : g_pad
      assign dbl = 4'd0;
    end else if (i == 0) begin : g_low
      assign dbl = {adj[i][2:0], ctrl.bit_in};
    end else begin : g_mid
      assign dbl = {adj[i][2:0], adj[i-1][3]};
    end
    if (i >= 4) begin : g_up
      assign grp_in = dig[i-4];
    end else begin : g_zero
      assign grp_in = 4'd0;
    end
    always_comb begin
      case (ctrl.op)
        BCD_CLEAR:  dig_next[i] = 4'd0;
        BCD_DOUBLE: dig_next[i] = dbl;
        BCD_GROUP:  dig_next[i] = grp_in;
        default:    dig_next[i] = dig[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    dig <= dig_next;
  end

  // leading group is read at a fixed place
  assign top_group = {dig[NDIG-1], dig[NDIG-2], dig[NDIG-3], dig[NDIG-4]};
  assign top_zero  = (top_group == '0);

endmodule

### design/cu2d_ctrl.sv
// sequencer: prefix decode, bit feed to the digit unit, group emission
// depends on cu2d_pkg
module cu2d_ctrl import cu2d_pkg::*; #(
  parameter int DEC_DIGITS = DEC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte,
  input  logic               out_free,
  output logic               load,
  output result_t            res,
  output bcd_ctrl_t          bcd,
  input  logic [GROUP_W-1:0] top_group,
  input  logic               top_zero
);

  localparam int NGRP = (DEC_DIGITS + 3) / 4;
  localparam int GW   = $clog2(NGRP);

  state_t          state, state_next;
  logic            in_payload;
  logic [5:0]      bytes_left;
  logic [LEN_W-1:0] enc_count;
  logic [7:0]      sh_byte;
  logic [3:0]      bit_cnt;
  logic            done_after;
  logic [GW-1:0]   grp;
  logic            started;

  logic       acc;
  logic [5:0] low;
  logic [6:0] len7;
  logic       too_long;
  logic       skip;
  logic       emit_now;

  assign acc      = in_valid && in_ready;
  assign low      = in_byte[5:0] & LOW_MASK;
  assign len7     = {1'b0, low} + 7'(LEN_BIAS);
  assign too_long = (len7 > 7'(MAX_VALUE_BYTES));
  assign skip     = !started && top_zero && (grp != '0);
  assign emit_now = !skip && out_free;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          if (in_payload || in_byte < PFX_LONG) begin
            state_next = ST_SHIFT;
          end else if (too_long) begin
            state_next = ST_ERR;
          end
        end
      end
      ST_SHIFT: begin
        if (bit_cnt == 4'd1) begin
          state_next = done_after ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_now && grp == '0) begin
          state_next = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = (state == ST_IDLE);
    bcd.op     = BCD_HOLD;
    bcd.bit_in = sh_byte[7];
    load       = 1'b0;
    res.digit_group     = top_group;
    res.digits_in_group = started ? NDIG_W'(4) : lead_digits(top_group);
    res.last_group      = (grp == '0);
    res.status          = 1'b0;
    res.encoded_length  = enc_count;
    case (state)
      ST_IDLE: begin
        if (acc && !in_payload) begin
          bcd.op = BCD_CLEAR;
        end
      end
      ST_SHIFT: bcd.op = BCD_DOUBLE;
      ST_EMIT: begin
        if (skip || emit_now) begin
          bcd.op = BCD_GROUP;
        end
        load = emit_now;
      end
      ST_ERR: begin
        load = out_free;
        res.digit_group     = '0;
        res.digits_in_group = '0;
        res.last_group      = 1'b1;
        res.status          = 1'b1;
        res.encoded_length  = LEN_W'(1);
      end
      default: bcd.op = BCD_HOLD;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      in_payload <= 1'b0;
      bytes_left <= '0;
      enc_count  <= '0;
      bit_cnt    <= '0;
      done_after <= 1'b0;
      grp        <= '0;
      started    <= 1'b0;
      sh_byte    <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (in_payload) begin
              enc_count  <= enc_count + 1'b1;
              bytes_left <= bytes_left - 1'b1;
              in_payload <= (bytes_left != 6'd1);
              done_after <= (bytes_left == 6'd1);
              sh_byte    <= in_byte;
              bit_cnt    <= 4'd8;
            end else begin
              enc_count <= LEN_W'(1);
              sh_byte   <= {low, 2'b00};
              bit_cnt   <= 4'd6;
              if (in_byte < PFX_TWO) begin
                done_after <= 1'b1;
              end else if (in_byte < PFX_FOUR) begin
                done_after <= 1'b0;
                bytes_left <= 6'd1;
                in_payload <= 1'b1;
              end else if (in_byte < PFX_LONG) begin
                done_after <= 1'b0;
                bytes_left <= 6'd3;
                in_payload <= 1'b1;
              end else if (too_long) begin
                bytes_left <= '0;
              end else begin
                bytes_left <= len7[5:0];
                in_payload <= 1'b1;
              end
            end
          end
        end
        ST_SHIFT: begin
          sh_byte <= {sh_byte[6:0], 1'b0};
          bit_cnt <= bit_cnt - 1'b1;
          grp     <= GW'(NGRP - 1);
          started <= 1'b0;
        end
        ST_EMIT: begin
          if (skip || emit_now) begin
            grp <= grp - 1'b1;
          end
          if (emit_now) begin
            started <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/cu2d_checker.sv
// port-level checks on the decoder output stream, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module cu2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  // stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

  // error result is a lone final transfer with no digits and one byte
  `ASSERT_IMPL(a_err_form, clk, rst, m_tvalid && m_tuser,
    m_tlast && m_tdata[18:16] == 3'd0 && m_tdata[24:19] == 6'd1)

  // good results carry one to four digits
  `ASSERT_IMPL(a_ok_count, clk, rst, m_tvalid && !m_tuser,
    m_tdata[18:16] != 3'd0 && m_tdata[18:16] <= 3'd4)

  // groups after the first of a value are full
  `ASSERT_NEXT(a_full_follow, clk, rst, m_tvalid && m_tready && !m_tlast,
    !m_tvalid || m_tdata[18:16] == 3'd4)

endmodule

bind compact_u256_to_decimal cu2d_checker u_cu2d_checker (.*);
